FILE: rtl/spcr_pkg.sv
// spcr_pkg: widths and status codes shared by the sphere pair collision response pipeline.
// no dependencies; used by spcr_isqrt, spcr_div and the top level.
`timescale 1ns / 1ps

package spcr_pkg;

	localparam int unsigned COMP_W = 16;
	localparam int unsigned VEC_W = 3 * COMP_W;
	localparam int unsigned RADIUS_W = 16;
	localparam int unsigned MASS_W = 16;
	localparam int unsigned REST_W = 17;

	// square root unit: 50-bit radicand, one root bit per stage
	localparam int unsigned SQ_ROOT_W = 25;
	localparam int unsigned SQ_IN_W = 2 * SQ_ROOT_W;
	localparam int unsigned SQ_REM_W = SQ_ROOT_W + 3;

	// divider unit: one quotient bit per stage
	localparam int unsigned DIV_N_W = 53;
	localparam int unsigned DIV_D_W = 25;
	localparam int unsigned DIV_Q_W = 36;
	localparam int unsigned DIV_CMP_W = DIV_D_W + DIV_Q_W;

	localparam logic [1:0] ST_RESOLVED = 2'd0;
	localparam logic [1:0] ST_NO_CONTACT = 2'd1;
	localparam logic [1:0] ST_BOTH_FIXED = 2'd2;
	localparam logic [1:0] ST_COINCIDENT = 2'd3;

endpackage

FILE: rtl/spcr_isqrt.sv
// spcr_isqrt: pipelined floor square root, one root bit per register stage.
// depends on spcr_pkg for widths.
`timescale 1ns / 1ps

module spcr_isqrt (
	input  logic                              clk,
	input  logic [spcr_pkg::SQ_IN_W-1:0]      x,
	output logic [spcr_pkg::SQ_ROOT_W-1:0]    root
);

	logic [spcr_pkg::SQ_REM_W-1:0] rem_s [spcr_pkg::SQ_ROOT_W];
	logic [spcr_pkg::SQ_ROOT_W-1:0] root_s [spcr_pkg::SQ_ROOT_W];
	logic [spcr_pkg::SQ_IN_W-1:0] x_s [spcr_pkg::SQ_ROOT_W];

	for (genvar k = 0; k < spcr_pkg::SQ_ROOT_W; k++) begin : g_stage
		logic [spcr_pkg::SQ_REM_W-1:0] rem_in;
		logic [spcr_pkg::SQ_ROOT_W-1:0] root_in;
		logic [spcr_pkg::SQ_IN_W-1:0] x_in;
		logic [spcr_pkg::SQ_REM_W-1:0] cur;
		logic [spcr_pkg::SQ_REM_W-1:0] trial;

		if (k == 0) begin : g_head
			assign rem_in = '0;
			assign root_in = '0;
			assign x_in = x;
		end else begin : g_body
			assign rem_in = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign x_in = x_s[k-1];
		end

		// bring down the next two radicand bits
		assign cur = {rem_in[spcr_pkg::SQ_REM_W-3:0], x_in[spcr_pkg::SQ_IN_W-1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (cur >= trial) begin
				rem_s[k] <= cur - trial;
				root_s[k] <= {root_in[spcr_pkg::SQ_ROOT_W-2:0], 1'b1};
			end else begin
				rem_s[k] <= cur;
				root_s[k] <= {root_in[spcr_pkg::SQ_ROOT_W-2:0], 1'b0};
			end
			x_s[k] <= {x_in[spcr_pkg::SQ_IN_W-3:0], 2'b00};
		end
	end

	assign root = root_s[spcr_pkg::SQ_ROOT_W-1];

endmodule

FILE: rtl/spcr_div.sv
// spcr_div: pipelined unsigned restoring divider, one quotient bit per register stage.
// depends on spcr_pkg; the dividend must stay below den * 2^DIV_Q_W.
`timescale 1ns / 1ps

module spcr_div (
	input  logic                            clk,
	input  logic [spcr_pkg::DIV_N_W-1:0]    num,
	input  logic [spcr_pkg::DIV_D_W-1:0]    den,
	output logic [spcr_pkg::DIV_Q_W-1:0]    quo
);

	logic [spcr_pkg::DIV_N_W-1:0] rem_s [spcr_pkg::DIV_Q_W];
	logic [spcr_pkg::DIV_D_W-1:0] den_s [spcr_pkg::DIV_Q_W];
	logic [spcr_pkg::DIV_Q_W-1:0] quo_s [spcr_pkg::DIV_Q_W];

	for (genvar s = 0; s < spcr_pkg::DIV_Q_W; s++) begin : g_stage
		logic [spcr_pkg::DIV_N_W-1:0] rem_in;
		logic [spcr_pkg::DIV_D_W-1:0] den_in;
		logic [spcr_pkg::DIV_Q_W-1:0] quo_in;
		logic [spcr_pkg::DIV_CMP_W-1:0] rem_w;
		logic [spcr_pkg::DIV_CMP_W-1:0] den_w;
		logic ge;

		if (s == 0) begin : g_head
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_body
			assign rem_in = rem_s[s-1];
			assign den_in = den_s[s-1];
			assign quo_in = quo_s[s-1];
		end

		// stage s decides quotient bit DIV_Q_W-1-s
		assign rem_w = spcr_pkg::DIV_CMP_W'(rem_in);
		assign den_w = spcr_pkg::DIV_CMP_W'(den_in) << (spcr_pkg::DIV_Q_W - 1 - s);
		assign ge = (rem_w >= den_w);

		always_ff @(posedge clk) begin
			rem_s[s] <= ge ? spcr_pkg::DIV_N_W'(rem_w - den_w) : rem_in;
			den_s[s] <= den_in;
			quo_s[s] <= {quo_in[spcr_pkg::DIV_Q_W-2:0], ge};
		end
	end

	assign quo = quo_s[spcr_pkg::DIV_Q_W-1];

endmodule

FILE: rtl/sphere_pair_collision_response.sv
// sphere_pair_collision_response: overlap test, positional push and restitution impulse.
// depends on spcr_pkg, spcr_isqrt and spcr_div.
// done follows start down a valid chain that runs beside the data registers; one pair
// per cycle, busy is always low. the path runs through the 25-stage square root and two
// 36-stage dividers (normal, then push and impulse shares).
// done cannot be held off. reset clears all valid bits and sets restitution to 0.
`timescale 1ns / 1ps

module sphere_pair_collision_response (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	output logic                              done,
	input  logic                              cfg_we,
	input  logic [spcr_pkg::REST_W-1:0]       cfg_wdata,
	input  logic [spcr_pkg::VEC_W-1:0]        pos_a,
	input  logic [spcr_pkg::VEC_W-1:0]        pos_b,
	input  logic [spcr_pkg::VEC_W-1:0]        vel_a,
	input  logic [spcr_pkg::VEC_W-1:0]        vel_b,
	input  logic [spcr_pkg::RADIUS_W-1:0]     radius_a,
	input  logic [spcr_pkg::RADIUS_W-1:0]     radius_b,
	input  logic [spcr_pkg::MASS_W-1:0]       mass_a,
	input  logic [spcr_pkg::MASS_W-1:0]       mass_b,
	input  logic                              fixed_a,
	input  logic                              fixed_b,
	output logic [spcr_pkg::VEC_W-1:0]        new_pos_a,
	output logic [spcr_pkg::VEC_W-1:0]        new_pos_b,
	output logic [spcr_pkg::VEC_W-1:0]        new_vel_a,
	output logic [spcr_pkg::VEC_W-1:0]        new_vel_b,
	output logic [1:0]                        status,
	output logic                              saturated
);

	localparam int unsigned CW = spcr_pkg::COMP_W;
	localparam int unsigned SQ_ST = spcr_pkg::SQ_ROOT_W;
	localparam int unsigned DQ = spcr_pkg::DIV_Q_W;
	localparam logic signed [23:0] CL_HI = 24'((1 << (CW - 1)) - 1);
	localparam logic signed [23:0] CL_LO = -CL_HI - 24'sd1;

	typedef struct packed {
		logic [spcr_pkg::VEC_W-1:0] pa;
		logic [spcr_pkg::VEC_W-1:0] pb;
		logic [spcr_pkg::VEC_W-1:0] va;
		logic [spcr_pkg::VEC_W-1:0] vb;
		logic [2:0][CW:0] d;
		logic [2:0][CW:0] dv;
		logic [spcr_pkg::MASS_W-1:0] ma;
		logic [spcr_pkg::MASS_W-1:0] mb;
		logic fa;
		logic fb;
		logic [16:0] rsum;
		logic [1:0] st;
		logic [24:0] pen;
	} ctx_t;

	typedef struct packed {
		ctx_t c;
		logic [2:0][17:0] n;
		logic [2:0] pneg;
		logic jneg;
	} mid_t;

	typedef struct packed {
		logic sat;
		logic [CW-1:0] val;
	} clamp_t;

	function automatic clamp_t clamp_comp(input logic signed [23:0] v);
		clamp_t r;
		if (v > CL_HI) begin
			r.sat = 1'b1;
			r.val = CW'(CL_HI);
		end else if (v < CL_LO) begin
			r.sat = 1'b1;
			r.val = CW'(CL_LO);
		end else begin
			r.sat = 1'b0;
			r.val = CW'(v);
		end
		return r;
	endfunction

	// round p / 2^32, halves away from zero
	function automatic logic signed [22:0] round32(input logic signed [54:0] p);
		logic [54:0] m;
		logic [22:0] r;
		m = p[54] ? 55'(-p) : 55'(p);
		r = 23'((m + 55'h8000_0000) >> 32);
		return p[54] ? -$signed(r) : $signed(r);
	endfunction

	logic [spcr_pkg::REST_W-1:0] restitution_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restitution_q <= '0;
		end else if (cfg_we) begin
			restitution_q <= cfg_wdata;
		end
	end

	assign busy = 1'b0;

	// valid chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic v_s12, v_s13, v_s14;
	logic [SQ_ST-1:0] v_sq_s;
	logic [DQ-1:0] v_nd_s;
	logic [DQ-1:0] v_id_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			v_s13 <= 1'b0; v_s14 <= 1'b0;
			v_sq_s <= '0;
			v_nd_s <= '0;
			v_id_s <= '0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_sq_s <= {v_sq_s[SQ_ST-2:0], v_s3};
			v_s4 <= v_sq_s[SQ_ST-1];
			v_nd_s <= {v_nd_s[DQ-2:0], v_s4};
			v_s5 <= v_nd_s[DQ-1];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_id_s <= {v_id_s[DQ-2:0], v_s11};
			v_s12 <= v_id_s[DQ-1];
			v_s13 <= v_s12;
			v_s14 <= v_s13;
		end
	end

	// s1: capture, differences, mass fix-up
	ctx_t c1, ctx_s1;

	always_comb begin
		c1 = '0;
		c1.pa = pos_a;
		c1.pb = pos_b;
		c1.va = vel_a;
		c1.vb = vel_b;
		for (int i = 0; i < 3; i++) begin
			c1.d[i] = {pos_a[i*CW+CW-1], pos_a[i*CW +: CW]}
				- {pos_b[i*CW+CW-1], pos_b[i*CW +: CW]};
			c1.dv[i] = {vel_a[i*CW+CW-1], vel_a[i*CW +: CW]}
				- {vel_b[i*CW+CW-1], vel_b[i*CW +: CW]};
		end
		c1.ma = (mass_a == '0) ? spcr_pkg::MASS_W'(1) : mass_a;
		c1.mb = (mass_b == '0) ? spcr_pkg::MASS_W'(1) : mass_b;
		c1.fa = fixed_a;
		c1.fb = fixed_b;
		c1.rsum = 17'(radius_a) + 17'(radius_b);
		c1.st = spcr_pkg::ST_RESOLVED;
	end

	always_ff @(posedge clk) begin
		ctx_s1 <= c1;
	end

	// s2: squares
	ctx_t ctx_s2;
	logic [31:0] sq_s2 [3];
	logic [33:0] rsq_s2;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= 32'($signed(ctx_s1.d[i]) * $signed(ctx_s1.d[i]));
		end
		rsq_s2 <= 34'(ctx_s1.rsum) * 34'(ctx_s1.rsum);
		ctx_s2 <= ctx_s1;
	end

	// s3: squared distance and status
	ctx_t ctx_s3;
	ctx_t c3;
	logic [33:0] d2_s3;
	logic [33:0] d2;

	assign d2 = 34'(sq_s2[0]) + 34'(sq_s2[1]) + 34'(sq_s2[2]);

	always_comb begin
		c3 = ctx_s2;
		if (!(d2 < rsq_s2)) begin
			c3.st = spcr_pkg::ST_NO_CONTACT;
		end else if (ctx_s2.fa && ctx_s2.fb) begin
			c3.st = spcr_pkg::ST_BOTH_FIXED;
		end else if (d2 == '0) begin
			c3.st = spcr_pkg::ST_COINCIDENT;
		end else begin
			c3.st = spcr_pkg::ST_RESOLVED;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s3 <= c3;
		d2_s3 <= d2;
	end

	// distance with 8 extra fraction bits
	logic [SQ_ST-1:0] dist_root;
	ctx_t ctx_sq_s [SQ_ST];

	spcr_isqrt u_isqrt (
		.clk  (clk),
		.x    ({d2_s3, 16'd0}),
		.root (dist_root)
	);

	always_ff @(posedge clk) begin
		ctx_sq_s[0] <= ctx_s3;
		for (int k = 1; k < SQ_ST; k++) begin
			ctx_sq_s[k] <= ctx_sq_s[k-1];
		end
	end

	// s4: normal numerators and penetration depth
	ctx_t ctx_s4;
	ctx_t c4;
	logic [spcr_pkg::DIV_N_W-1:0] nnum_s4 [3];
	logic [spcr_pkg::DIV_D_W-1:0] dist_s4;

	always_comb begin
		c4 = ctx_sq_s[SQ_ST-1];
		c4.pen = {ctx_sq_s[SQ_ST-1].rsum, 8'd0} - dist_root;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			nnum_s4[i] <= spcr_pkg::DIV_N_W'(
				{(ctx_sq_s[SQ_ST-1].d[i][CW] ? CW'(-ctx_sq_s[SQ_ST-1].d[i])
					: CW'(ctx_sq_s[SQ_ST-1].d[i])), 24'd0}
				+ 40'(dist_root >> 1));
		end
		dist_s4 <= spcr_pkg::DIV_D_W'(dist_root);
		ctx_s4 <= c4;
	end

	logic [DQ-1:0] nq [3];
	ctx_t ctx_nd_s [DQ];

	for (genvar i = 0; i < 3; i++) begin : g_ndiv
		spcr_div u_div (
			.clk (clk),
			.num (nnum_s4[i]),
			.den (dist_s4),
			.quo (nq[i])
		);
	end

	always_ff @(posedge clk) begin
		ctx_nd_s[0] <= ctx_s4;
		for (int k = 1; k < DQ; k++) begin
			ctx_nd_s[k] <= ctx_nd_s[k-1];
		end
	end

	// s5: signed unit normal, Q16
	mid_t m_s5;
	mid_t m5;

	always_comb begin
		m5 = '0;
		m5.c = ctx_nd_s[DQ-1];
		for (int i = 0; i < 3; i++) begin
			m5.n[i] = ctx_nd_s[DQ-1].d[i][CW] ? -{1'b0, nq[i][16:0]} : {1'b0, nq[i][16:0]};
		end
	end

	always_ff @(posedge clk) begin
		m_s5 <= m5;
	end

	// s6: push and approach products
	mid_t m_s6;
	logic signed [43:0] pn_s6 [3];
	logic signed [34:0] vp_s6 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pn_s6[i] <= $signed({1'b0, m_s5.c.pen}) * $signed(m_s5.n[i]);
			vp_s6[i] <= $signed(m_s5.n[i]) * $signed(m_s5.c.dv[i]);
		end
		m_s6 <= m_s5;
	end

	// s7: mass shares of the push, normal velocity
	mid_t m_s7;
	mid_t m7;
	logic [57:0] pam_s7 [3];
	logic [57:0] pbm_s7 [3];
	logic signed [34:0] vn_s7;
	logic [spcr_pkg::MASS_W-1:0] mul_a;
	logic [spcr_pkg::MASS_W-1:0] mul_b;

	// a fixed sphere takes no push and the other takes all of it
	always_comb begin
		if (m_s6.c.fa) begin
			mul_a = '0;
			mul_b = spcr_pkg::MASS_W'(1);
		end else if (m_s6.c.fb) begin
			mul_a = spcr_pkg::MASS_W'(1);
			mul_b = '0;
		end else begin
			mul_a = m_s6.c.mb;
			mul_b = m_s6.c.ma;
		end
	end

	always_comb begin
		m7 = m_s6;
		for (int i = 0; i < 3; i++) begin
			m7.pneg[i] = pn_s6[i][43];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pam_s7[i] <= 58'(pn_s6[i][43] ? 42'(-pn_s6[i]) : 42'(pn_s6[i])) * 58'(mul_a);
			pbm_s7[i] <= 58'(pn_s6[i][43] ? 42'(-pn_s6[i]) : 42'(pn_s6[i])) * 58'(mul_b);
		end
		vn_s7 <= vp_s6[0] + vp_s6[1] + vp_s6[2];
		m_s7 <= m7;
	end

	// s8: push dividends with the rounding half folded in, impulse scaling
	mid_t m_s8;
	logic [33:0] yna_s8 [3];
	logic [33:0] ynb_s8 [3];
	logic signed [53:0] jprod_s8;
	logic [16:0] divs7;
	logic [17:0] rest_fac;

	assign divs7 = (m_s7.c.fa || m_s7.c.fb) ? 17'd1 : 17'(m_s7.c.ma) + 17'(m_s7.c.mb);
	assign rest_fac = 18'(65536) + 18'(restitution_q);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			yna_s8[i] <= 34'((pam_s7[i] + (58'(divs7) << 23)) >> 24);
			ynb_s8[i] <= 34'((pbm_s7[i] + (58'(divs7) << 23)) >> 24);
		end
		jprod_s8 <= vn_s7 * $signed({1'b0, rest_fac});
		m_s8 <= m_s7;
	end

	// s9: impulse j, magnitude and sign
	mid_t m_s9;
	mid_t m9;
	logic [33:0] yna_s9 [3];
	logic [33:0] ynb_s9 [3];
	logic [35:0] jm_s9;
	logic [52:0] jmag;

	assign jmag = jprod_s8[53] ? 53'(-jprod_s8) : 53'(jprod_s8);

	always_comb begin
		m9 = m_s8;
		m9.jneg = jprod_s8[53];
	end

	always_ff @(posedge clk) begin
		yna_s9 <= yna_s8;
		ynb_s9 <= ynb_s8;
		jm_s9 <= 36'((jmag + 53'd32768) >> 16);
		m_s9 <= m9;
	end

	// s10: impulse mass products
	mid_t m_s10;
	logic [33:0] yna_s10 [3];
	logic [33:0] ynb_s10 [3];
	logic [51:0] jam_s10;
	logic [51:0] jbm_s10;

	always_ff @(posedge clk) begin
		yna_s10 <= yna_s9;
		ynb_s10 <= ynb_s9;
		jam_s10 <= 52'(jm_s9) * 52'(m_s9.c.mb);
		jbm_s10 <= 52'(jm_s9) * 52'(m_s9.c.ma);
		m_s10 <= m_s9;
	end

	// s11: divider operands
	mid_t m_s11;
	logic [spcr_pkg::DIV_N_W-1:0] num_pa_s11 [3];
	logic [spcr_pkg::DIV_N_W-1:0] num_pb_s11 [3];
	logic [spcr_pkg::DIV_N_W-1:0] num_ja_s11;
	logic [spcr_pkg::DIV_N_W-1:0] num_jb_s11;
	logic [spcr_pkg::DIV_D_W-1:0] divs_s11;
	logic [spcr_pkg::DIV_D_W-1:0] msum_s11;
	logic [16:0] msum10;

	assign msum10 = 17'(m_s10.c.ma) + 17'(m_s10.c.mb);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			num_pa_s11[i] <= spcr_pkg::DIV_N_W'(yna_s10[i]);
			num_pb_s11[i] <= spcr_pkg::DIV_N_W'(ynb_s10[i]);
		end
		num_ja_s11 <= spcr_pkg::DIV_N_W'(jam_s10) + spcr_pkg::DIV_N_W'(msum10 >> 1);
		num_jb_s11 <= spcr_pkg::DIV_N_W'(jbm_s10) + spcr_pkg::DIV_N_W'(msum10 >> 1);
		divs_s11 <= (m_s10.c.fa || m_s10.c.fb) ? spcr_pkg::DIV_D_W'(1)
			: spcr_pkg::DIV_D_W'(msum10);
		msum_s11 <= spcr_pkg::DIV_D_W'(msum10);
		m_s11 <= m_s10;
	end

	logic [DQ-1:0] qpa [3];
	logic [DQ-1:0] qpb [3];
	logic [DQ-1:0] qja;
	logic [DQ-1:0] qjb;
	mid_t m_id_s [DQ];

	for (genvar i = 0; i < 3; i++) begin : g_pdiv
		spcr_div u_div_a (
			.clk (clk),
			.num (num_pa_s11[i]),
			.den (divs_s11),
			.quo (qpa[i])
		);
		spcr_div u_div_b (
			.clk (clk),
			.num (num_pb_s11[i]),
			.den (divs_s11),
			.quo (qpb[i])
		);
	end

	spcr_div u_div_ja (
		.clk (clk),
		.num (num_ja_s11),
		.den (msum_s11),
		.quo (qja)
	);

	spcr_div u_div_jb (
		.clk (clk),
		.num (num_jb_s11),
		.den (msum_s11),
		.quo (qjb)
	);

	always_ff @(posedge clk) begin
		m_id_s[0] <= m_s11;
		for (int k = 1; k < DQ; k++) begin
			m_id_s[k] <= m_id_s[k-1];
		end
	end

	// s12: signed pushes and impulse shares
	mid_t m_s12;
	logic signed [18:0] push_a_s12 [3];
	logic signed [18:0] push_b_s12 [3];
	logic signed [36:0] ja_s12;
	logic signed [36:0] jb_s12;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			push_a_s12[i] <= m_id_s[DQ-1].pneg[i] ? -$signed({1'b0, qpa[i][17:0]})
				: $signed({1'b0, qpa[i][17:0]});
			push_b_s12[i] <= m_id_s[DQ-1].pneg[i] ? -$signed({1'b0, qpb[i][17:0]})
				: $signed({1'b0, qpb[i][17:0]});
		end
		ja_s12 <= m_id_s[DQ-1].jneg ? -$signed({1'b0, qja}) : $signed({1'b0, qja});
		jb_s12 <= m_id_s[DQ-1].jneg ? -$signed({1'b0, qjb}) : $signed({1'b0, qjb});
		m_s12 <= m_id_s[DQ-1];
	end

	// s13: velocity change products
	mid_t m_s13;
	logic signed [18:0] push_a_s13 [3];
	logic signed [18:0] push_b_s13 [3];
	logic signed [54:0] dva_s13 [3];
	logic signed [54:0] dvb_s13 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dva_s13[i] <= ja_s12 * $signed(m_s12.n[i]);
			dvb_s13[i] <= jb_s12 * $signed(m_s12.n[i]);
		end
		push_a_s13 <= push_a_s12;
		push_b_s13 <= push_b_s12;
		m_s13 <= m_s12;
	end

	// s14: apply, saturate, pack
	logic [spcr_pkg::VEC_W-1:0] npa, npb, nva, nvb;
	logic nsat;

	always_comb begin
		logic signed [23:0] wide;
		clamp_t cl;
		npa = '0;
		npb = '0;
		nva = '0;
		nvb = '0;
		nsat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			wide = $signed(m_s13.c.pa[i*CW +: CW]) + push_a_s13[i];
			cl = clamp_comp(wide);
			npa[i*CW +: CW] = cl.val;
			nsat = nsat | cl.sat;
			wide = $signed(m_s13.c.pb[i*CW +: CW]) - push_b_s13[i];
			cl = clamp_comp(wide);
			npb[i*CW +: CW] = cl.val;
			nsat = nsat | cl.sat;
			wide = $signed(m_s13.c.va[i*CW +: CW]) - round32(dva_s13[i]);
			cl = clamp_comp(wide);
			nva[i*CW +: CW] = cl.val;
			nsat = nsat | cl.sat;
			wide = $signed(m_s13.c.vb[i*CW +: CW]) + round32(dvb_s13[i]);
			cl = clamp_comp(wide);
			nvb[i*CW +: CW] = cl.val;
			nsat = nsat | cl.sat;
		end
	end

	logic [spcr_pkg::VEC_W-1:0] pos_a_s14, pos_b_s14, vel_a_s14, vel_b_s14;
	logic [1:0] status_s14;
	logic sat_s14;

	always_ff @(posedge clk) begin
		status_s14 <= m_s13.c.st;
		if (m_s13.c.st == spcr_pkg::ST_RESOLVED) begin
			pos_a_s14 <= npa;
			pos_b_s14 <= npb;
			vel_a_s14 <= nva;
			vel_b_s14 <= nvb;
			sat_s14 <= nsat;
		end else begin
			pos_a_s14 <= m_s13.c.pa;
			pos_b_s14 <= m_s13.c.pb;
			vel_a_s14 <= m_s13.c.va;
			vel_b_s14 <= m_s13.c.vb;
			sat_s14 <= 1'b0;
		end
	end

	assign done = v_s14;
	assign new_pos_a = pos_a_s14;
	assign new_pos_b = pos_b_s14;
	assign new_vel_a = vel_a_s14;
	assign new_vel_b = vel_b_s14;
	assign status = status_s14;
	assign saturated = sat_s14;

endmodule
